// File: src/rlc_pkg.sv
// Package for the rudder limit calibration block.
// Holds widths, constants, microcode word types and the microcode ROM.
// No dependencies.
package rlc_pkg;

    localparam int POT_BITS = 12;
    localparam int POT_IN_W = 12;
    localparam int ANGLE_W  = 14;
    localparam int MAG_W    = 13;
    localparam int BAND_W   = 13;
    localparam int PHASE_W  = 3;

    localparam int QUO_W    = 14;
    localparam int CNT_W    = $clog2(QUO_W);
    localparam int SPAN_W   = POT_BITS + 1;
    localparam int REM_W    = SPAN_W + 1;
    localparam int T_W      = POT_BITS + 3;
    localparam int TM_W     = POT_BITS + 1;
    localparam int PROD_W   = MAG_W + TM_W;
    localparam int NUM_W    = PROD_W + 1;

    localparam logic [MAG_W-1:0]          ANGLE_MAX  = MAG_W'(7854);
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIM  = ANGLE_W'(7854);
    localparam logic [BAND_W-1:0]         BAND_RESET = BAND_W'(1000);

    localparam logic [PHASE_W-1:0] PHC_IDLE        = 3'd0;
    localparam logic [PHASE_W-1:0] PHC_INIT        = 3'd1;
    localparam logic [PHASE_W-1:0] PHC_FIRST_PORT  = 3'd2;
    localparam logic [PHASE_W-1:0] PHC_FIRST_STAR  = 3'd3;
    localparam logic [PHASE_W-1:0] PHC_SECOND_PORT = 3'd4;
    localparam logic [PHASE_W-1:0] PHC_SECOND_STAR = 3'd5;
    localparam logic [PHASE_W-1:0] PHC_RECENTER    = 3'd6;

    localparam int PC_W = 3;

    localparam logic [PC_W-1:0] STEP_LOAD = 3'd0;
    localparam logic [PC_W-1:0] STEP_MUL  = 3'd1;
    localparam logic [PC_W-1:0] STEP_PREP = 3'd2;
    localparam logic [PC_W-1:0] STEP_DIV  = 3'd3;
    localparam logic [PC_W-1:0] STEP_FIN  = 3'd4;
    localparam logic [PC_W-1:0] STEP_UPD  = 3'd5;
    localparam logic [PC_W-1:0] STEP_EMIT = 3'd6;

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_IN_VALID = 2'd1,
        COND_DIV_DONE = 2'd2,
        COND_OUT_FREE = 2'd3
    } cond_t;

    typedef struct packed {
        logic             ld;
        logic             mul;
        logic             prep;
        logic             div;
        logic             fin;
        logic             upd;
        logic             emit;
        cond_t            cond;
        logic             jump;
        logic [PC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        logic take;
        logic ld;
        logic mul;
        logic prep;
        logic div;
        logic fin;
        logic upd;
        logic emit;
    } ops_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic div_done;
    } seq_flags_t;

    typedef struct packed {
        logic               dir;
        logic               run;
        logic               calibrated;
        logic               calibrating;
        logic               save;
        logic [PHASE_W-1:0] phase;
    } cal_status_t;

    // Step holds until its condition is true, then falls through or jumps.
    function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
        uword_t w;
        w = '0;
        case (pc)
            STEP_LOAD:
            begin
                w.ld   = 1'b1;
                w.cond = COND_IN_VALID;
            end
            STEP_MUL:  w.mul  = 1'b1;
            STEP_PREP: w.prep = 1'b1;
            STEP_DIV:
            begin
                w.div  = 1'b1;
                w.cond = COND_DIV_DONE;
            end
            STEP_FIN:  w.fin  = 1'b1;
            STEP_UPD:  w.upd  = 1'b1;
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.jump   = 1'b1;
                w.target = STEP_LOAD;
            end
            default:
            begin
                w.jump   = 1'b1;
                w.target = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

// File: src/rlc_in_if.sv
// Sample channel: valid/ready handshake with one sensor sample as payload.
// Depends on rlc_pkg.
interface rlc_in_if import rlc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [POT_IN_W-1:0] pot_value;
    logic                at_port_limit;
    logic                at_starboard_limit;
    logic                start_request;

    modport source (
        output valid, pot_value, at_port_limit, at_starboard_limit, start_request,
        input  ready
    );
    modport sink (
        input  valid, pot_value, at_port_limit, at_starboard_limit, start_request,
        output ready
    );
endinterface

// File: src/rlc_out_if.sv
// Result channel: valid/ready handshake with angle and calibration status.
// Depends on rlc_pkg.
interface rlc_out_if import rlc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [ANGLE_W-1:0]  rudder_angle;
    logic                       drive_direction;
    logic                       drive_run;
    logic                       is_calibrated;
    logic                       is_calibrating;
    logic [POT_IN_W-1:0]        port_reading;
    logic [POT_IN_W-1:0]        starboard_reading;
    logic                       save_pulse;
    logic [PHASE_W-1:0]         phase;

    modport source (
        output valid, rudder_angle, drive_direction, drive_run, is_calibrated,
               is_calibrating, port_reading, starboard_reading, save_pulse, phase,
        input  ready
    );
    modport sink (
        input  valid, rudder_angle, drive_direction, drive_run, is_calibrated,
               is_calibrating, port_reading, starboard_reading, save_pulse, phase,
        output ready
    );
endinterface

// File: src/rlc_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup, wait/jump logic.
// Depends on rlc_pkg (ucode_rom, uword_t, ops_t).
module rlc_sequencer import rlc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output ops_t       ops
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          w;
    logic            go;

    always_comb
    begin
        w = ucode_rom(pc_reg);
        case (w.cond)
            COND_ALWAYS:   go = 1'b1;
            COND_IN_VALID: go = flags.in_valid;
            COND_DIV_DONE: go = flags.div_done;
            COND_OUT_FREE: go = flags.out_free;
            default:       go = 1'b1;
        endcase

        pc_next = pc_reg;
        if (go)
        begin
            pc_next = w.jump ? w.target : pc_reg + PC_W'(1);
        end

        ops.take = w.ld;
        ops.ld   = w.ld & go;
        ops.mul  = w.mul;
        ops.prep = w.prep;
        ops.div  = w.div;
        ops.fin  = w.fin;
        ops.upd  = w.upd;
        ops.emit = w.emit & go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: src/rlc_angle_unit.sv
// Angle datapath: span/offset, one constant multiply, restoring divider
// (one quotient bit per step), rounding, clamp and sign. Depends on rlc_pkg.
module rlc_angle_unit import rlc_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ops_t                      ops,
    input  logic [POT_BITS-1:0]       pot_in,
    input  logic [POT_BITS-1:0]       port_latch,
    input  logic [POT_BITS-1:0]       stb_latch,
    output logic [POT_BITS-1:0]       pot,
    output logic signed [ANGLE_W-1:0] angle,
    output logic [MAG_W-1:0]          mag,
    output logic                      div_done
);

    logic [POT_BITS-1:0]       pot_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [POT_BITS-1:0]       dmag_reg;
    logic                      neg_reg;
    logic                      zero_reg;
    logic                      off_pos_reg;
    logic                      off_neg_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [QUO_W-1:0]          low_reg;
    logic [QUO_W-1:0]          q_reg;
    logic                      ovf_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [MAG_W-1:0]          mag_reg;

    logic signed [T_W-1:0]     t_val;
    logic signed [T_W-1:0]     t_neg;
    logic [TM_W-1:0]           tmag;
    logic [POT_BITS-1:0]       dmag;
    logic [NUM_W-1:0]          num_val;
    logic [SPAN_W-1:0]         den;
    logic [REM_W-1:0]          trial;
    logic                      fits;
    logic [MAG_W-1:0]          qclamp;
    logic [MAG_W-1:0]          m_sel;
    logic                      neg_sel;
    logic [ANGLE_W-1:0]        m_ext;

    always_comb
    begin
        // 7854*(span - 2*off) with span - 2*off = stb + port - 2*pot
        t_val = $signed(T_W'(stb_latch)) + $signed(T_W'(port_latch))
              - $signed(T_W'({pot_reg, 1'b0}));
        t_neg = -t_val;
        tmag  = t_val[T_W-1] ? t_neg[TM_W-1:0] : t_val[TM_W-1:0];
        dmag  = (stb_latch >= port_latch) ? stb_latch - port_latch
                                          : port_latch - stb_latch;

        // q = (2*|num| + |span|) / (2*|span|)
        num_val = {prod_reg, 1'b0} + NUM_W'(dmag_reg);
        den     = {dmag_reg, 1'b0};
        trial   = {rem_reg[SPAN_W-1:0], low_reg[QUO_W-1]};
        fits    = trial >= REM_W'(den);

        qclamp  = (ovf_reg || q_reg > QUO_W'(ANGLE_MAX)) ? ANGLE_MAX : q_reg[MAG_W-1:0];
        if (zero_reg)
        begin
            m_sel   = (off_pos_reg || off_neg_reg) ? ANGLE_MAX : '0;
            neg_sel = off_pos_reg;
        end
        else
        begin
            m_sel   = qclamp;
            neg_sel = neg_reg;
        end
        m_ext = {1'b0, m_sel};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ops.prep)
        begin
            cnt_reg <= '0;
        end
        else if (ops.div)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ops.ld)
        begin
            pot_reg <= pot_in;
        end
        if (ops.mul)
        begin
            prod_reg    <= PROD_W'(ANGLE_MAX) * PROD_W'(tmag);
            dmag_reg    <= dmag;
            neg_reg     <= t_val[T_W-1] ^ (stb_latch < port_latch);
            zero_reg    <= stb_latch == port_latch;
            off_pos_reg <= pot_reg > port_latch;
            off_neg_reg <= pot_reg < port_latch;
        end
        if (ops.prep)
        begin
            rem_reg <= REM_W'(num_val[NUM_W-1:QUO_W]);
            low_reg <= num_val[QUO_W-1:0];
            ovf_reg <= num_val[NUM_W-1:QUO_W] >= den;
            q_reg   <= '0;
        end
        if (ops.div)
        begin
            rem_reg <= fits ? trial - REM_W'(den) : trial;
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            q_reg   <= {q_reg[QUO_W-2:0], fits};
        end
        if (ops.fin)
        begin
            angle_reg <= neg_sel ? -m_ext : m_ext;
            mag_reg   <= m_sel;
        end
    end

    assign pot      = pot_reg;
    assign angle    = angle_reg;
    assign mag      = mag_reg;
    assign div_done = cnt_reg == CNT_W'(QUO_W - 1);

endmodule

// File: src/rlc_cal_state.sv
// Calibration sequence: phase state machine, end-stop latches and flags.
// Depends on rlc_pkg (ops_t, cal_status_t, phase codes).
module rlc_cal_state import rlc_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  ops_t                ops,
    input  logic                start,
    input  logic                port_lim,
    input  logic                star_lim,
    input  logic [POT_BITS-1:0] pot,
    input  logic [MAG_W-1:0]    mag,
    input  logic [BAND_W-1:0]   band,
    output logic [POT_BITS-1:0] port_latch,
    output logic [POT_BITS-1:0] stb_latch,
    output cal_status_t         status
);

    typedef enum logic [6:0] {
        PH_IDLE        = 7'b0000001,
        PH_INIT        = 7'b0000010,
        PH_FIRST_PORT  = 7'b0000100,
        PH_FIRST_STAR  = 7'b0001000,
        PH_SECOND_PORT = 7'b0010000,
        PH_SECOND_STAR = 7'b0100000,
        PH_RECENTER    = 7'b1000000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [POT_BITS-1:0] port_reg, port_next;
    logic [POT_BITS-1:0] stb_reg, stb_next;
    logic                cald_reg, cald_next;
    logic                caling_reg, caling_next;
    logic                run_reg, run_next;
    logic                dir_reg, dir_next;
    logic                save_reg, save_next;
    logic                plim_reg;
    logic                slim_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        port_next   = port_reg;
        stb_next    = stb_reg;
        cald_next   = cald_reg;
        caling_next = caling_reg;
        run_next    = run_reg;
        dir_next    = dir_reg;
        save_next   = save_reg;

        if (ops.ld && start && !caling_reg)
        begin
            phase_next = PH_INIT;
        end

        if (ops.upd)
        begin
            save_next = 1'b0;
            case (phase_reg)
                PH_INIT:
                begin
                    cald_next   = 1'b0;
                    caling_next = 1'b1;
                    run_next    = 1'b1;
                    port_next   = '0;
                    stb_next    = '0;
                    phase_next  = slim_reg ? PH_FIRST_PORT : PH_FIRST_STAR;
                    dir_next    = slim_reg;
                end
                PH_FIRST_PORT:
                begin
                    if (plim_reg)
                    begin
                        port_next  = pot;
                        phase_next = PH_SECOND_STAR;
                        dir_next   = 1'b0;
                    end
                end
                PH_FIRST_STAR:
                begin
                    if (slim_reg)
                    begin
                        stb_next   = pot;
                        phase_next = PH_SECOND_PORT;
                        dir_next   = 1'b1;
                    end
                end
                PH_SECOND_PORT:
                begin
                    if (plim_reg)
                    begin
                        port_next  = pot;
                        save_next  = 1'b1;
                        phase_next = PH_RECENTER;
                        dir_next   = 1'b0;
                        cald_next  = 1'b1;
                    end
                end
                PH_SECOND_STAR:
                begin
                    if (slim_reg)
                    begin
                        stb_next   = pot;
                        save_next  = 1'b1;
                        phase_next = PH_RECENTER;
                        dir_next   = 1'b1;
                        cald_next  = 1'b1;
                    end
                end
                PH_RECENTER:
                begin
                    if (BAND_W'(mag) < band)
                    begin
                        run_next    = 1'b0;
                        caling_next = 1'b0;
                        phase_next  = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            port_reg   <= '0;
            stb_reg    <= '0;
            cald_reg   <= 1'b0;
            caling_reg <= 1'b0;
            run_reg    <= 1'b0;
            dir_reg    <= 1'b0;
            save_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            port_reg   <= port_next;
            stb_reg    <= stb_next;
            cald_reg   <= cald_next;
            caling_reg <= caling_next;
            run_reg    <= run_next;
            dir_reg    <= dir_next;
            save_reg   <= save_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ops.ld)
        begin
            plim_reg <= port_lim;
            slim_reg <= star_lim;
        end
    end

    always_comb
    begin
        case (phase_reg)
            PH_IDLE:        status.phase = PHC_IDLE;
            PH_INIT:        status.phase = PHC_INIT;
            PH_FIRST_PORT:  status.phase = PHC_FIRST_PORT;
            PH_FIRST_STAR:  status.phase = PHC_FIRST_STAR;
            PH_SECOND_PORT: status.phase = PHC_SECOND_PORT;
            PH_SECOND_STAR: status.phase = PHC_SECOND_STAR;
            PH_RECENTER:    status.phase = PHC_RECENTER;
            default:        status.phase = PHC_IDLE;
        endcase
        status.dir         = dir_reg;
        status.run         = run_reg;
        status.calibrated  = cald_reg;
        status.calibrating = caling_reg;
        status.save        = save_reg;
    end

    assign port_latch = port_reg;
    assign stb_latch  = stb_reg;

endmodule

// File: src/rudder_limit_calibration_core.sv
// Rudder limit calibration core: one sample in, one angle/status result out.
// Each sample transaction runs load, multiply, prepare, the 14-step restoring divider, finish,
// update and emit under the microcode sequencer; the next sample is taken only after emit.
// A waiting result sits in the output register while the next sample is taken.
// Reset (rst_n low, asynchronous): idle phase, latches and flags cleared, band 1000.
// Depends on rlc_pkg, rlc_in_if, rlc_out_if, rlc_sequencer, rlc_angle_unit, rlc_cal_state.
module rudder_limit_calibration_core import rlc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    rlc_in_if.sink             sample,
    rlc_out_if.source          result,
    input  logic               cfg_we,
    input  logic [BAND_W-1:0]  cfg_data
);

    ops_t                      ops;
    seq_flags_t                flags;
    cal_status_t               status;
    logic [BAND_W-1:0]         band_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [POT_BITS-1:0]       pot;
    logic [POT_BITS-1:0]       port_latch;
    logic [POT_BITS-1:0]       stb_latch;
    logic signed [ANGLE_W-1:0] angle;
    logic [MAG_W-1:0]          mag;
    logic                      div_done;

    logic signed [ANGLE_W-1:0] angle_out_reg;
    cal_status_t               status_out_reg;
    logic [POT_IN_W-1:0]       port_out_reg;
    logic [POT_IN_W-1:0]       stb_out_reg;

    assign flags.in_valid = sample.valid;
    assign flags.out_free = !out_valid_reg || result.ready;
    assign flags.div_done = div_done;
    assign sample.ready   = ops.take;

    rlc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ops   (ops)
    );

    rlc_angle_unit u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .ops        (ops),
        .pot_in     (POT_BITS'(sample.pot_value)),
        .port_latch (port_latch),
        .stb_latch  (stb_latch),
        .pot        (pot),
        .angle      (angle),
        .mag        (mag),
        .div_done   (div_done)
    );

    rlc_cal_state u_cal (
        .clk        (clk),
        .rst_n      (rst_n),
        .ops        (ops),
        .start      (sample.start_request),
        .port_lim   (sample.at_port_limit),
        .star_lim   (sample.at_starboard_limit),
        .pot        (pot),
        .mag        (mag),
        .band       (band_reg),
        .port_latch (port_latch),
        .stb_latch  (stb_latch),
        .status     (status)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ops.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg      <= BAND_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                band_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ops.emit)
        begin
            angle_out_reg  <= angle;
            status_out_reg <= status;
            port_out_reg   <= POT_IN_W'(port_latch);
            stb_out_reg    <= POT_IN_W'(stb_latch);
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.rudder_angle      = angle_out_reg;
    assign result.drive_direction   = status_out_reg.dir;
    assign result.drive_run         = status_out_reg.run;
    assign result.is_calibrated     = status_out_reg.calibrated;
    assign result.is_calibrating    = status_out_reg.calibrating;
    assign result.port_reading      = port_out_reg;
    assign result.starboard_reading = stb_out_reg;
    assign result.save_pulse        = status_out_reg.save;
    assign result.phase             = status_out_reg.phase;

    a_one_sample_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("sample taken while previous one still in work");

    a_run_tracks_calibrating: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.drive_run == result.is_calibrating)
        else $error("drive_run and is_calibrating disagree");

    a_phase_tracks_calibrating: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.is_calibrating == (result.phase != PHC_IDLE))
        else $error("phase and is_calibrating disagree");

    a_save_implies_calibrated: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.save_pulse |-> result.is_calibrated)
        else $error("save_pulse without is_calibrated");

    a_angle_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.rudder_angle <= ANGLE_LIM
                         && result.rudder_angle >= -ANGLE_LIM)
        else $error("rudder_angle outside clamp range");

endmodule
